// ===== hw/rtl/lla_pkg.sv =====
// Shared constants for the log line assembler.
package lla_pkg;

  localparam logic [7:0] NewlineChar = 8'h0A;
  localparam logic [7:0] PrintLow    = 8'h20;
  localparam logic [7:0] PrintHigh   = 8'h7E;
  localparam logic [7:0] SubstChar   = 8'h2E;
  localparam int unsigned MarkLen    = 6;

  localparam logic OpData  = 1'b0;
  localparam logic OpFlush = 1'b1;

  // " [cut]"
  function automatic logic [7:0] mark_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = 8'h20;
      3'd1:    c = 8'h5B;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h75;
      3'd4:    c = 8'h74;
      default: c = 8'h5D;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/log_line_assembler.sv =====
// Log line assembler: byte stream in, packed line words out.
//
// channel | dir | tdata (low bit up)   | tuser (low bit up)          | tlast
// s_axis  | in  | data_byte[7:0]       | operation                   | -
// m_axis  | out | char_word[31:0]      | valid_chars[2:0], was_cut   | last_of_line
//
// A flush of N chars streams ceil(N/4) words, one per cycle while the output is not
// stalled, from four byte-lane banks with registered reads; input is held off
// until the last word has been read. The first byte past a full line writes the
// six-byte marker, one byte per cycle, holding input off while it is written.
// Output stalls freeze the read pipeline. Reset clears length, cut flag and state;
// the line store is not cleared.
module log_line_assembler
  import lla_pkg::*;
#(
  parameter int unsigned LINE_LEN = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tuser_i,   // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // char_word
  output logic [3:0]  m_axis_tuser_o,   // valid_chars[2:0], was_cut
  output logic        m_axis_tlast_o    // last_of_line
);

  localparam int unsigned LenW  = $clog2(LINE_LEN + 1);
  localparam int unsigned Rows  = (LINE_LEN + 3) / 4;
  localparam int unsigned RowW  = $clog2(Rows);
  localparam int unsigned MarkBase = LINE_LEN - MarkLen;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StMark  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic            cut_q, cut_d;
  logic [2:0]      mk_q, mk_d;

  logic            out_valid_q, out_valid_d;
  logic [2:0]      out_cnt_q, out_cnt_d;
  logic            out_last_q, out_last_d;
  logic            out_cut_q, out_cut_d;

  logic [7:0]      rdata_q [4];

  logic            in_xfer;
  logic            is_flush;
  logic [7:0]      clean_byte;
  logic            wr_en;
  logic [LenW-1:0] wr_idx;
  logic [7:0]      wr_byte;
  logic            rd_en;
  logic [RowW-1:0] rd_row;
  logic [LenW-1:0] rem;
  logic            rem_last;
  logic [LenW-1:0] mark_idx;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_flush = (s_axis_tuser_i == OpFlush) || (s_axis_tdata_i == NewlineChar);
  assign clean_byte = (s_axis_tdata_i < PrintLow || s_axis_tdata_i > PrintHigh) ?
                      SubstChar : s_axis_tdata_i;

  assign rem      = len_q - pos_q;
  assign rem_last = (rem <= LenW'(4));
  assign rd_en    = (state_q == StFlush) && (!out_valid_q || m_axis_tready_i);
  assign rd_row   = pos_q[RowW+1:2];
  assign mark_idx = LenW'(MarkBase) + LenW'(mk_q);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pos_d       = pos_q;
    cut_d       = cut_q;
    mk_d        = mk_q;
    out_valid_d = out_valid_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    out_cut_d   = out_cut_q;
    wr_en       = 1'b0;
    wr_idx      = len_q;
    wr_byte     = clean_byte;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (is_flush) begin
            if (len_q != '0) begin
              state_d = StFlush;
              pos_d   = '0;
            end else begin
              cut_d = 1'b0;
            end
          end else if (len_q < LenW'(LINE_LEN)) begin
            wr_en = 1'b1;
            len_d = len_q + LenW'(1);
          end else if (!cut_q) begin
            cut_d   = 1'b1;
            mk_d    = '0;
            state_d = StMark;
          end
        end
      end
      StMark: begin
        wr_en   = 1'b1;
        wr_idx  = mark_idx;
        wr_byte = mark_char(mk_q);
        mk_d    = mk_q + 3'd1;
        if (mk_q == 3'(MarkLen - 1)) begin
          state_d = StIdle;
        end
      end
      StFlush: begin
        if (rd_en) begin
          out_valid_d = 1'b1;
          out_cnt_d   = rem_last ? rem[2:0] : 3'd4;
          out_last_d  = rem_last;
          out_cut_d   = cut_q;
          pos_d       = pos_q + LenW'(4);
          if (rem_last) begin
            state_d = StIdle;
            len_d   = '0;
            cut_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      pos_q       <= '0;
      cut_q       <= 1'b0;
      mk_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      cut_q       <= cut_d;
      mk_q        <= mk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
    out_cut_q  <= out_cut_d;
  end

  // four byte lanes, char index i lives in lane i[1:0], row i>>2
  for (genvar b = 0; b < 4; b++) begin : g_lane
    logic [7:0] mem [Rows];

    always_ff @(posedge clk_i) begin
      if (wr_en && wr_idx[1:0] == 2'(b)) begin
        mem[wr_idx[RowW+1:2]] <= wr_byte;
      end
      if (rd_en) begin
        rdata_q[b] <= mem[rd_row];
      end
    end

    assign m_axis_tdata_o[8*b +: 8] = (3'(b) < out_cnt_q) ? rdata_q[b] : 8'h00;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = {out_cut_q, out_cnt_q};
  assign m_axis_tlast_o  = out_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cnt_q != 3'd0 && out_cnt_q <= 3'd4))
    else $error("word char count out of range");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(LINE_LEN))
    else $error("line length overflow");

  a_flush_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush) |-> (pos_q < len_q))
    else $error("flush read past line end");

  a_mark_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMark) |-> (cut_q && len_q == LenW'(LINE_LEN)))
    else $error("marker written on a line that is not full");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && rem_last) |=> (len_q == '0 && !cut_q && state_q == StIdle))
    else $error("line state not cleared after flush");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for log_line_assembler: directed table plus random lines, scoreboarded.
`timescale 1ns / 100ps

module tb
  import lla_pkg::*;
();

  localparam int LINE_LEN = 128;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [47:0] CUT_MARK = " [cut]";

  typedef struct packed {
    logic [31:0] chars;
    logic [2:0]  count;
    logic        last;
    logic        cut;
  } line_word_t;

  typedef struct {
    logic       op;
    logic [7:0] b;
    bit         typed;
    line_word_t w;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'h00;
  logic        s_user = OpData;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  logic [3:0]  m_user;
  logic        m_last;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int sent_items = 0;
  int mismatches = 0;
  int cycles = 0;

  // predicted line state
  logic [7:0] line_chars [LINE_LEN];
  int         line_fill = 0;
  bit         line_cut = 1'b0;
  line_word_t line_words [$];

  line_word_t got_word, want_word;
  stim_row_t  dir_rows [22];

  log_line_assembler #(
    .LINE_LEN(LINE_LEN)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic predict_item(input logic op, input logic [7:0] b);
    logic [7:0] c;
    int         pos;
    int         n;
    line_word_t w;
    if (op == OpFlush || b == NewlineChar) begin
      pos = 0;
      while (pos < line_fill) begin
        n = line_fill - pos;
        if (n > 4) n = 4;
        w = '0;
        for (int k = 0; k < n; k++) w.chars[8*k +: 8] = line_chars[pos + k];
        pos += n;
        w.count = 3'(n);
        w.last = (pos >= line_fill);
        w.cut = line_cut;
        line_words.push_back(w);
      end
      line_fill = 0;
      line_cut = 1'b0;
    end else begin
      c = (b < PrintLow || b > PrintHigh) ? SubstChar : b;
      if (line_fill < LINE_LEN) begin
        line_chars[line_fill] = c;
        line_fill++;
      end else if (!line_cut) begin
        line_cut = 1'b1;
        for (int k = 0; k < int'(MarkLen); k++)
          line_chars[LINE_LEN - int'(MarkLen) + k] = CUT_MARK[8*(5-k) +: 8];
      end
    end
  endtask

  // one transfer on the slave side; entered and left at a falling edge
  task automatic send_item(input logic op, input logic [7:0] b, input bit typed,
                           input line_word_t typed_word);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid = 1'b0;
      @(negedge clk);
    end
    s_valid = 1'b1;
    s_data = b;
    s_user = op;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    predict_item(op, b);
    if (typed) begin
      if (line_words.size() > 0) void'(line_words.pop_back());
      line_words.push_back(typed_word);
    end
    sent_items++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] line_byte();
    if ($urandom_range(99) < 80) return 8'($urandom_range(PrintLow, PrintHigh));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_line(input int len, input bit by_flush);
    for (int i = 0; i < len; i++) send_item(OpData, line_byte(), 1'b0, '0);
    if (by_flush) send_item(OpFlush, 8'($urandom_range(255)), 1'b0, '0);
    else send_item(OpData, NewlineChar, 1'b0, '0);
  endtask

  task automatic drain_lines();
    s_valid = 1'b0;
    while (line_words.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) m_ready = ($urandom_range(99) >= snk_idle_pct);

  task automatic note_mismatch(input line_word_t want, input line_word_t got, input bit orphan);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan)
        $display("%0t: unexpected word %h cnt %0d last %b cut %b", $time,
                 got.chars, got.count, got.last, got.cut);
      else
        $display("%0t: exp %h cnt %0d last %b cut %b / got %h cnt %0d last %b cut %b",
                 $time, want.chars, want.count, want.last, want.cut,
                 got.chars, got.count, got.last, got.cut);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      got_word = {m_data, m_user[2:0], m_last, m_user[3]};
      if (line_words.size() == 0) begin
        note_mismatch('0, got_word, 1'b1);
      end else begin
        want_word = line_words.pop_front();
        if (got_word !== want_word) note_mismatch(want_word, got_word, 1'b0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int target;
    int kind;
    dir_rows = '{
      '{OpFlush, 8'h00, 1'b0, '0},
      '{OpData,  8'h0A, 1'b0, '0},
      '{OpData,  8'h41, 1'b0, '0},
      '{OpData,  8'h00, 1'b0, '0},
      '{OpData,  8'hFF, 1'b0, '0},
      '{OpData,  8'h20, 1'b0, '0},
      '{OpData,  8'h0A, 1'b1, '{32'h202E2E41, 3'd4, 1'b1, 1'b0}},
      '{OpData,  8'h7E, 1'b0, '0},
      '{OpData,  8'h1F, 1'b0, '0},
      '{OpData,  8'h7F, 1'b0, '0},
      '{OpFlush, 8'hA5, 1'b1, '{32'h002E2E7E, 3'd3, 1'b1, 1'b0}},
      '{OpData,  8'h55, 1'b0, '0},
      '{OpFlush, 8'h0A, 1'b1, '{32'h00000055, 3'd1, 1'b1, 1'b0}},
      '{OpFlush, 8'hFF, 1'b0, '0},
      '{OpData,  8'h80, 1'b0, '0},
      '{OpData,  8'h21, 1'b0, '0},
      '{OpData,  8'h5A, 1'b0, '0},
      '{OpData,  8'h30, 1'b0, '0},
      '{OpData,  8'h31, 1'b0, '0},
      '{OpData,  8'h0A, 1'b0, '0},
      '{OpData,  8'h0A, 1'b0, '0},
      '{OpFlush, 8'h00, 1'b0, '0}
    };
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    src_idle_pct = 32;
    snk_idle_pct = 57;
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].w);
    drain_lines();

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 57 : 0;
      snk_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 32 : 0;
      // full line, first byte past full, one byte dropped after the marker
      if (phase == 0) send_line(LINE_LEN + 2, 1'b0);
      target = sent_items + 36;
      while (sent_items < target) begin
        kind = $urandom_range(99);
        if (kind < 5) drain_lines();
        if (kind < 65) begin
          send_line($urandom_range(0, 12), $urandom_range(3) == 0);
        end else if (kind < 80) begin
          send_line($urandom_range(13, 40), $urandom_range(3) == 0);
        end else if (kind < 83) begin
          send_line($urandom_range(41, 60), $urandom_range(1) == 0);
        end else begin
          repeat ($urandom_range(1, 6))
            send_item(($urandom_range(4) == 0) ? OpFlush : OpData,
                      8'($urandom_range(255)), 1'b0, '0);
        end
      end
      drain_lines();
    end

    s_valid = 1'b0;
    while (line_words.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && line_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lla_pkg.sv
hw/rtl/log_line_assembler.sv
tb/sv/tb.sv
